// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the pixel dither block.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PDN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdn assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdn assertion failed");

`endif

// File: hdl/pdn_pkg.sv
// Shared types, constants and table functions of the pixel dither block.
// No dependencies; used by the hash round, the output stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pdn_pkg;

  localparam logic [31:0] HASH_MULT = 32'd1103515245;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DITHER_MODE = 2'd0;
  localparam logic [1:0] CFG_FIELD_SHIFT = 2'd1;
  localparam logic [1:0] CFG_HOLD_NOISE  = 2'd2;

  // Color dither sources, dither_mode bits 3:2.
  localparam logic [1:0] RGB_MAGIC = 2'd0;
  localparam logic [1:0] RGB_BAYER = 2'd1;
  localparam logic [1:0] RGB_NOISE = 2'd2;
  localparam logic [1:0] RGB_CONST = 2'd3;

  // Alpha dither sources, dither_mode bits 1:0.
  localparam logic [1:0] ALPHA_MATRIX = 2'd0;
  localparam logic [1:0] ALPHA_INVERT = 2'd1;
  localparam logic [1:0] ALPHA_NOISE  = 2'd2;
  localparam logic [1:0] ALPHA_ZERO   = 2'd3;

  localparam logic [2:0] CONST_DITHER   = 3'd7;
  localparam logic [5:0] COMB_NOISE_LOW = 6'h20;
  localparam logic [7:0] CHAN_SAT_LIMIT = 8'd247;
  localparam logic [7:0] CHAN_MAX       = 8'hff;
  localparam logic [7:0] CHAN_STEP      = 8'd8;

  typedef struct packed {
    logic [3:0] dither_mode;
    logic       field_shift;
    logic [1:0] hold_noise_level;
  } pdn_cfg_t;

  // Pixel data that rides along the hash pipeline.
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pdn_side_t;

  function automatic logic [2:0] magic4(input logic [3:0] idx);
    logic [2:0] v;
    case (idx)
      4'd0:  v = 3'd0;
      4'd1:  v = 3'd6;
      4'd2:  v = 3'd1;
      4'd3:  v = 3'd7;
      4'd4:  v = 3'd4;
      4'd5:  v = 3'd2;
      4'd6:  v = 3'd5;
      4'd7:  v = 3'd3;
      4'd8:  v = 3'd3;
      4'd9:  v = 3'd5;
      4'd10: v = 3'd2;
      4'd11: v = 3'd4;
      4'd12: v = 3'd7;
      4'd13: v = 3'd1;
      4'd14: v = 3'd6;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] bayer4(input logic [3:0] idx);
    logic [2:0] v;
    case (idx)
      4'd0:  v = 3'd0;
      4'd1:  v = 3'd4;
      4'd2:  v = 3'd1;
      4'd3:  v = 3'd5;
      4'd4:  v = 3'd4;
      4'd5:  v = 3'd0;
      4'd6:  v = 3'd5;
      4'd7:  v = 3'd1;
      4'd8:  v = 3'd3;
      4'd9:  v = 3'd7;
      4'd10: v = 3'd2;
      4'd11: v = 3'd6;
      4'd12: v = 3'd7;
      4'd13: v = 3'd3;
      4'd14: v = 3'd6;
      default: v = 3'd2;
    endcase
    return v;
  endfunction

  // Round a channel up to the next multiple of eight when its low bits
  // exceed the dither value, saturating at full scale.
  function automatic logic [7:0] dither_chan(input logic [7:0] v, input logic [2:0] comp);
    logic [7:0] up;
    up = (v > CHAN_SAT_LIMIT) ? CHAN_MAX : ({v[7:3], 3'b000} + CHAN_STEP);
    return (comp < v[2:0]) ? up : v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pdn_hash_round.sv
// One registered round of the three-word multiply hash, with pixel data alongside.
// Depends on pdn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdn_hash_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       a_in,
  input  logic [31:0]       b_in,
  input  logic [31:0]       c_in,
  input  pdn_pkg::pdn_side_t side_in,
  output logic              out_valid,
  output logic [31:0]       a_out,
  output logic [31:0]       b_out,
  output logic [31:0]       c_out,
  output pdn_pkg::pdn_side_t side_out
);
  import pdn_pkg::*;

  logic        valid_r;
  logic [31:0] a_r, b_r, c_r;
  logic [31:0] a_nxt, b_nxt, c_nxt;
  pdn_side_t   side_r;

  // Only the low 32 bits of each product are kept.
  assign a_nxt = ((a_in >> 8) ^ b_in) * HASH_MULT;
  assign b_nxt = ((b_in >> 8) ^ c_in) * HASH_MULT;
  assign c_nxt = ((c_in >> 8) ^ a_in) * HASH_MULT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      side_r <= side_in;
    end
  end

  assign out_valid = valid_r;
  assign a_out     = a_r;
  assign b_out     = b_r;
  assign c_out     = c_r;
  assign side_out  = side_r;

endmodule

`default_nettype wire

// File: hdl/pdn_dither.sv
// Output stage: dither source selection, channel rounding and the combiner noise register.
// Depends on pdn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdn_dither (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        seed,
  input  pdn_pkg::pdn_side_t side_in,
  input  pdn_pkg::pdn_cfg_t  cfg,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [8:0]         color_dither,
  output logic [2:0]         alpha_dither,
  output logic [15:0]        seed_out,
  output logic [8:0]         combiner_noise,
  output logic [7:0]         blend_threshold
);
  import pdn_pkg::*;

  logic       valid_r;
  logic [8:0] hold_r, hold_nxt;
  logic [7:0] red_r, green_r, blue_r;
  logic [8:0] cd_r, cd_nxt;
  logic [2:0] ad_r, ad_nxt;
  logic [15:0] seed_r;
  logic [1:0] rgb_sel, a_sel;
  logic [2:0] magic_v, bayer_v, matrix_v;
  logic [2:0] rc, gc, bc;

  assign rgb_sel = cfg.dither_mode[3:2];
  assign a_sel   = cfg.dither_mode[1:0];
  assign magic_v = magic4(side_in.idx);
  assign bayer_v = bayer4(side_in.idx);

  always_comb begin
    case (rgb_sel)
      RGB_MAGIC: cd_nxt = {6'd0, magic_v};
      RGB_BAYER: cd_nxt = {6'd0, bayer_v};
      RGB_NOISE: cd_nxt = seed[8:0];
      default:   cd_nxt = {6'd0, CONST_DITHER};
    endcase
    // The alpha matrix follows the color matrix; noise color uses magic,
    // constant color uses Bayer.
    matrix_v = (rgb_sel == RGB_MAGIC || rgb_sel == RGB_NOISE) ? magic_v : bayer_v;
    case (a_sel)
      ALPHA_MATRIX: ad_nxt = matrix_v;
      ALPHA_INVERT: ad_nxt = ~matrix_v;
      ALPHA_NOISE:  ad_nxt = seed[2:0];
      default:      ad_nxt = 3'd0;
    endcase
    if (rgb_sel == RGB_NOISE) begin
      rc = cd_nxt[2:0];
      gc = cd_nxt[5:3];
      bc = cd_nxt[8:6];
    end else begin
      rc = cd_nxt[2:0];
      gc = cd_nxt[2:0];
      bc = cd_nxt[2:0];
    end
  end

  assign hold_nxt = (cfg.hold_noise_level == 2'd0) ? {seed[2:0], COMB_NOISE_LOW} : hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hold_r  <= 9'd0;
    end else if (en) begin
      valid_r <= in_valid;
      if (in_valid) begin
        hold_r <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= dither_chan(side_in.red, rc);
      green_r <= dither_chan(side_in.green, gc);
      blue_r  <= dither_chan(side_in.blue, bc);
      cd_r    <= cd_nxt;
      ad_r    <= ad_nxt;
      seed_r  <= seed;
    end
  end

  assign out_valid       = valid_r;
  assign red             = red_r;
  assign green           = green_r;
  assign blue            = blue_r;
  assign color_dither    = cd_r;
  assign alpha_dither    = ad_r;
  assign seed_out        = seed_r;
  assign combiner_noise  = hold_r;
  assign blend_threshold = seed_r[7:0];

endmodule

`default_nettype wire

// File: hdl/pixel_dither_noise_unit.sv
// Pixel dither and noise unit: input staging, three hash rounds and the output stage.
// Depends on pdn_pkg, pdn_hash_round and pdn_dither.
`timescale 1ns / 1ps
`default_nettype none

// Applies 4x4 ordered dither (magic or Bayer matrix), hashed noise dither or
// constant dither to one RGB pixel per request and reports the alpha dither,
// the 16-bit noise seed, the combiner noise and the blend threshold. The unit
// takes one request per clock while its output is not held: the accepting
// edge loads the first of three stages that each run one round of the
// multiply hash (one 32x32 multiply per word per stage), and a
// fourth register stage holds the dithered result. All stages move
// together, so when the output is held by a low out_ready the whole pipeline
// stalls and in_ready drops in the same cycle; with out_ready high the unit
// streams without gaps. Configuration is written through cfg_we, cfg_index and
// cfg_wdata and may change only while no request is in flight. The combiner
// noise register is updated as each result enters the output stage, so
// combiner_noise always shows the value after that pixel.
module pixel_dither_noise_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [31:0] in_noise_offset,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [8:0]  out_color_dither,
  output logic [2:0]  out_alpha_dither,
  output logic [15:0] out_noise_seed,
  output logic [8:0]  out_combiner_noise,
  output logic [7:0]  out_blend_threshold
);
  import pdn_pkg::*;

  pdn_cfg_t    cfg_r;
  logic        en;
  pdn_side_t   side0, side1, side2, side3;
  logic        v1, v2, v3;
  logic [31:0] a1, b1, c1, a2, b2, c2, a3, b3, c3;
  logic [1:0]  y_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DITHER_MODE: cfg_r.dither_mode      <= cfg_wdata;
        CFG_FIELD_SHIFT: cfg_r.field_shift      <= cfg_wdata[0];
        CFG_HOLD_NOISE:  cfg_r.hold_noise_level <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is empty or draining.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Matrix row comes from y, optionally shifted down by one for field rendering.
  assign y_sel       = cfg_r.field_shift ? in_pixel_y[2:1] : in_pixel_y[1:0];
  assign side0.idx   = {y_sel, in_pixel_x[1:0]};
  assign side0.red   = in_red_in;
  assign side0.green = in_green_in;
  assign side0.blue  = in_blue_in;

  pdn_hash_round u_round1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .a_in({20'd0, in_pixel_x}), .b_in({20'd0, in_pixel_y}), .c_in(in_noise_offset),
    .side_in(side0),
    .out_valid(v1), .a_out(a1), .b_out(b1), .c_out(c1), .side_out(side1)
  );

  pdn_hash_round u_round2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1),
    .a_in(a1), .b_in(b1), .c_in(c1), .side_in(side1),
    .out_valid(v2), .a_out(a2), .b_out(b2), .c_out(c2), .side_out(side2)
  );

  pdn_hash_round u_round3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2),
    .a_in(a2), .b_in(b2), .c_in(c2), .side_in(side2),
    .out_valid(v3), .a_out(a3), .b_out(b3), .c_out(c3), .side_out(side3)
  );

  // Only the x word of the last round forms the seed; the other two words end here.
  pdn_dither u_dither (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3),
    .seed(a3[31:16]), .side_in(side3), .cfg(cfg_r),
    .out_valid(out_valid),
    .red(out_red_out), .green(out_green_out), .blue(out_blue_out),
    .color_dither(out_color_dither), .alpha_dither(out_alpha_dither),
    .seed_out(out_noise_seed), .combiner_noise(out_combiner_noise),
    .blend_threshold(out_blend_threshold)
  );

  // The b and c words of the final round carry no result.
  logic unused_words;
  assign unused_words = ^{b3, c3};

endmodule

`default_nettype wire

// File: hdl/pdn_checker.sv
// Port-level checker of the pixel dither block and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdn_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        cfg_we,
  input wire [1:0]  cfg_index,
  input wire [3:0]  cfg_wdata,
  input wire        in_valid,
  input wire        in_ready,
  input wire [11:0] in_pixel_x,
  input wire [11:0] in_pixel_y,
  input wire [31:0] in_noise_offset,
  input wire [7:0]  in_red_in,
  input wire [7:0]  in_green_in,
  input wire [7:0]  in_blue_in,
  input wire        out_valid,
  input wire        out_ready,
  input wire [7:0]  out_red_out,
  input wire [7:0]  out_green_out,
  input wire [7:0]  out_blue_out,
  input wire [8:0]  out_color_dither,
  input wire [2:0]  out_alpha_dither,
  input wire [15:0] out_noise_seed,
  input wire [8:0]  out_combiner_noise,
  input wire [7:0]  out_blend_threshold
);

  // A stalled result stays offered.
  `PDN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its channels, color dither, seed and combiner noise.
  `PDN_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out) && $stable(out_color_dither) && $stable(out_noise_seed) && $stable(out_combiner_noise))

  // An empty output stage must never block new requests.
  `PDN_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // The blend threshold is the low byte of the seed of the same pixel.
  `PDN_ASSERT_IMP(a_blend_seed, out_valid, out_blend_threshold == out_noise_seed[7:0])

endmodule

bind pixel_dither_noise_unit pdn_checker u_pdn_checker (.*);

`default_nettype wire
